// File: design/sm4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// sm4 shared types, constants, s-box and round-function helpers
package sm4_pkg;

	localparam int WORD_W   = 32;
	localparam int HALF_W   = 64;
	localparam int ROUNDS   = 32;
	localparam int ROUND_W  = $clog2(ROUNDS);
	localparam int CFG_IDX_W = 2;

	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [HALF_W-1:0]    half_t;
	typedef logic [ROUND_W-1:0]   round_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// register indexes on the configuration port
	localparam cfg_idx_t CFG_KEY_HIGH     = 2'd0;
	localparam cfg_idx_t CFG_KEY_LOW      = 2'd1;
	localparam cfg_idx_t CFG_DECRYPT_MODE = 2'd2;

	localparam half_t KEY_HIGH_RST = 64'h0123_4567_89AB_CDEF;
	localparam half_t KEY_LOW_RST  = 64'hFEDC_BA98_7654_3210;

	// system parameter fk
	localparam word_t FK0 = 32'hA3B1_BAC6;
	localparam word_t FK1 = 32'h56AA_3350;
	localparam word_t FK2 = 32'h677D_9197;
	localparam word_t FK3 = 32'hB270_22DC;

	localparam logic [7:0] SBOX_TAB [0:255] = '{
		8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
		8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
		8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
		8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
		8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
		8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
		8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
		8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
		8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
		8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
		8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
		8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
		8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
		8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
		8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
	};

	// byte-wise s-box, four lookups side by side
	function automatic word_t sm4_tau(input word_t a);
		return {SBOX_TAB[a[31:24]], SBOX_TAB[a[23:16]], SBOX_TAB[a[15:8]], SBOX_TAB[a[7:0]]};
	endfunction

	function automatic word_t rotl(input word_t x, input int n);
		return (x << n) | (x >> (WORD_W - n));
	endfunction

	// linear layer of the data rounds
	function automatic word_t sm4_lin(input word_t b);
		return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	// linear layer of the key schedule
	function automatic word_t sm4_lin_key(input word_t b);
		return b ^ rotl(b, 13) ^ rotl(b, 23);
	endfunction

	// ck[i]: byte j is 7 * (4i + j) mod 256
	function automatic word_t sm4_ck(input round_t i);
		word_t w;
		logic [7:0] base;
		base = {1'b0, i, 2'b00};
		w = '0;
		for (int j = 0; j < 4; j++) begin
			w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
		end
		return w;
	endfunction

endpackage
`default_nettype wire

// File: design/sm4_if.sv
`timescale 1ns / 1ps
`default_nettype none
// valid/ready channels for input blocks and result blocks
interface sm4_in_if;
	logic valid;
	logic ready;
	sm4_pkg::half_t block_high;
	sm4_pkg::half_t block_low;

	modport source (output valid, output block_high, output block_low, input ready);
	modport sink   (input valid, input block_high, input block_low, output ready);
endinterface

interface sm4_out_if;
	logic valid;
	logic ready;
	sm4_pkg::half_t result_high;
	sm4_pkg::half_t result_low;

	modport source (output valid, output result_high, output result_low, input ready);
	modport sink   (input valid, input result_high, input result_low, output ready);
endinterface
`default_nettype wire

// File: design/sm4_block_cipher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// sm4 block cipher core: one shared round unit, stored round keys
//
// SM4 128-bit block cipher with a 128-bit key taken from the configuration
// port (key_high at index 0, key_low at index 1, decrypt_mode bit 0 at
// index 2; other indexes are ignored). Write registers only while the core
// is idle. A single round unit (four s-box lookups plus the linear layer)
// is reused for both the key schedule and the data rounds. The first item
// after reset or after a key write first expands the key into 32 round
// keys, one per cycle, kept in a 32x32 round-key memory; later items skip
// this. Each item goes through a round-key prefetch, 32 rounds and an
// output load, after the key expansion when one is needed. The round
// unit and the single read port of the round-key memory allow one round
// per cycle. The core accepts one item at a time; the output register
// holds a finished result, so a new item may be accepted while it waits
// to be taken. Decrypt mode reads the stored round keys in reverse order;
// changing the mode needs no expansion. Results come out as words X35,
// X34 (result_high) and X33, X32 (result_low).
module sm4_block_cipher_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  sm4_pkg::cfg_idx_t   cfg_index,
	input  sm4_pkg::half_t      cfg_data,
	sm4_in_if.sink              in_ch,
	sm4_out_if.source           out_ch
);
	import sm4_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXPAND = 3'd1;
	localparam logic [2:0] ST_FETCH  = 3'd2;
	localparam logic [2:0] ST_RUN    = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	logic [2:0] state_q;
	round_t     round_q;
	logic       keys_ready_q;
	half_t      key_high_q;
	half_t      key_low_q;
	logic       decrypt_q;

	// working words, key words during expansion, data words during rounds
	word_t x0_q, x1_q, x2_q, x3_q;
	half_t blk_high_q, blk_low_q;
	word_t rk_q;
	word_t rk_mem [ROUNDS];

	half_t res_high_q, res_low_q;
	logic  out_valid_q;

	logic   in_fire;
	logic   expanding;
	word_t  unit_in, unit_sub, unit_out;
	round_t rd_round, rd_addr;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign expanding   = (state_q == ST_EXPAND);

	// shared round unit
	always_comb begin
		unit_in  = x1_q ^ x2_q ^ x3_q ^ (expanding ? sm4_ck(round_q) : rk_q);
		unit_sub = sm4_tau(unit_in);
		unit_out = x0_q ^ (expanding ? sm4_lin_key(unit_sub) : sm4_lin(unit_sub));
	end

	// prefetch address: round 0 in fetch, the next round while running
	always_comb begin
		rd_round = (state_q == ST_RUN) ? round_q + 1'b1 : '0;
		rd_addr  = decrypt_q ? ~rd_round : rd_round;
	end

	// round-key memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (expanding) begin
			rk_mem[round_q] <= unit_out;
		end
		rk_q <= rk_mem[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= KEY_HIGH_RST;
			key_low_q  <= KEY_LOW_RST;
			decrypt_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_HIGH:     key_high_q <= cfg_data;
				CFG_KEY_LOW:      key_low_q  <= cfg_data;
				CFG_DECRYPT_MODE: decrypt_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			round_q      <= '0;
			keys_ready_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					round_q <= '0;
					if (in_fire) begin
						state_q <= keys_ready_q ? ST_FETCH : ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					round_q <= round_q + 1'b1;
					if (round_q == round_t'(ROUNDS - 1)) begin
						keys_ready_q <= 1'b1;
						state_q      <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					round_q <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					round_q <= round_q + 1'b1;
					if (round_q == round_t'(ROUNDS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// a key write forces a fresh expansion before the next item
			if (cfg_we && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW)) begin
				keys_ready_q <= 1'b0;
			end
		end
	end

	// working words and held input block
	always_ff @(posedge clk) begin
		if (in_fire) begin
			blk_high_q <= in_ch.block_high;
			blk_low_q  <= in_ch.block_low;
			if (keys_ready_q) begin
				{x0_q, x1_q} <= in_ch.block_high;
				{x2_q, x3_q} <= in_ch.block_low;
			end else begin
				x0_q <= key_high_q[63:32] ^ FK0;
				x1_q <= key_high_q[31:0]  ^ FK1;
				x2_q <= key_low_q[63:32]  ^ FK2;
				x3_q <= key_low_q[31:0]   ^ FK3;
			end
		end else if (expanding && round_q == round_t'(ROUNDS - 1)) begin
			// schedule done, bring in the held block
			{x0_q, x1_q} <= blk_high_q;
			{x2_q, x3_q} <= blk_low_q;
		end else if (expanding || state_q == ST_RUN) begin
			x0_q <= x1_q;
			x1_q <= x2_q;
			x2_q <= x3_q;
			x3_q <= unit_out;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid_q || out_ch.ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || out_ch.ready)) begin
			res_high_q <= {x3_q, x2_q};
			res_low_q  <= {x1_q, x0_q};
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.result_high = res_high_q;
	assign out_ch.result_low  = res_low_q;

endmodule
`default_nettype wire
